// ===== sv/hvn_pkg.sv =====
// Shared types, codes and constants of the heightmap vertex normal stream.
`default_nettype none

package hvn_pkg;

    // Input word kinds
    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_FLUSH = 1'b1;

    // Configuration register indexes
    localparam logic [2:0] CFG_GRID_SIZE     = 3'd0;
    localparam logic [2:0] CFG_HEIGHT_GAIN   = 3'd1;
    localparam logic [2:0] CFG_HEIGHT_OFFSET = 3'd2;
    localparam logic [2:0] CFG_POSITION_STEP = 3'd3;
    localparam logic [2:0] CFG_TEXTURE_STEP  = 3'd4;

    // Configuration reset values
    localparam logic [8:0]  GRID_SIZE_RST     = 9'd256;
    localparam logic [15:0] HEIGHT_GAIN_RST   = 16'd20480;
    localparam logic [22:0] HEIGHT_OFFSET_RST = 23'd10240;
    localparam logic [15:0] POSITION_STEP_RST = 16'd803;
    localparam logic [16:0] TEXTURE_STEP_RST  = 17'd257;

    // Divide by three as multiply by reciprocal, exact for sums up to 765
    localparam logic [9:0] DIV3_MUL   = 10'd683;
    localparam int         DIV3_SHIFT = 11;

    // Saturation limits of the coordinate outputs
    localparam logic [23:0] POS_MAX = 24'hFFFFFF;
    localparam logic [16:0] TEX_MAX = 17'd65536;

    // Vertex request from the frame sequencer to the vertex datapath
    typedef struct packed {
        logic        has_left;
        logic        has_right;
        logic        has_down;
        logic        has_up;
        logic        last;
        logic [7:0]  up_avg;
        logic [15:0] index;
    } vtx_req_t;

    // Height of one average, signed Q15.8
    function automatic logic signed [23:0] height_of(
        input logic [7:0]  avg,
        input logic [15:0] gain,
        input logic [22:0] offset
    );
        logic [23:0]        prod;
        logic signed [24:0] diff;
        prod = 24'(avg) * 24'(gain);
        diff = $signed({9'd0, prod[23:8]}) - $signed({2'd0, offset});
        return $signed(diff[23:0]);
    endfunction

endpackage

`default_nettype wire

// ===== sv/hvn_line_store.sv =====
// Line store memory: one write port, two registered read ports.
`default_nettype none

module hvn_line_store #(
    parameter int ADDR_W = 9
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [7:0]        wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr_a,
    input  wire logic [ADDR_W-1:0] rd_addr_b,
    output logic      [7:0]        rd_data_a,
    output logic      [7:0]        rd_data_b
);

    logic [7:0] line_mem [2**ADDR_W];
    logic [7:0] rd_data_a_reg;
    logic [7:0] rd_data_b_reg;

    // Read-first: a read of the address being written returns the old word
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            line_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_a_reg <= line_mem[rd_addr_a];
            rd_data_b_reg <= line_mem[rd_addr_b];
        end
    end

    assign rd_data_a = rd_data_a_reg;
    assign rd_data_b = rd_data_b_reg;

endmodule

`default_nettype wire

// ===== sv/hvn_frame_ctrl.sv =====
// Frame sequencer: raster counters, line store addressing and vertex requests.
`default_nettype none

module hvn_frame_ctrl #(
    parameter int  MAX_GRID = 256,
    localparam int CW       = $clog2(MAX_GRID),
    localparam int AW       = CW + 1
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic [8:0]       grid_size,
    input  wire logic             accept,
    input  wire logic             kind,
    input  wire logic [7:0]       red,
    input  wire logic [7:0]       green,
    input  wire logic [7:0]       blue,
    output logic                  emit,
    output hvn_pkg::vtx_req_t     req,
    output logic      [CW-1:0]    vtx_row,
    output logic      [CW-1:0]    vtx_col,
    output logic                  wr_en,
    output logic      [AW-1:0]    wr_addr,
    output logic      [7:0]       wr_data,
    output logic      [AW-1:0]    rd_center,
    output logic      [AW-1:0]    rd_left,
    output logic      [AW-1:0]    rd_right,
    output logic      [AW-1:0]    rd_down
);

    localparam int GW   = $clog2(MAX_GRID + 1);
    localparam int TW   = GW + 1;
    localparam int CMPW = (GW > 9) ? GW : 9;

    logic [CW-1:0] col_reg,   col_next;
    logic [GW-1:0] row_reg,   row_next;
    logic [15:0]   count_reg, count_next;

    logic [CMPW-1:0] gs_ext;
    logic [GW-1:0]   g;
    logic            wrap;
    logic            restart;
    logic [TW-1:0]   row_t;
    logic [CW-1:0]   col_s;
    logic [GW-1:0]   row_s;
    logic [15:0]     cnt_s;
    logic [GW-1:0]   col_inc;
    logic            col_end;
    logic            pix_take;
    logic            pix_emit;
    logic            flush_emit;
    logic [GW-1:0]   vr;
    logic [9:0]      sum;
    logic [19:0]     avg_prod;
    logic [7:0]      avg;

    // Channel average, truncated
    always_comb
    begin
        sum      = 10'(red) + 10'(green) + 10'(blue);
        avg_prod = 20'(sum) * 20'(hvn_pkg::DIV3_MUL);
        avg      = 8'(avg_prod >> hvn_pkg::DIV3_SHIFT);
    end

    always_comb
    begin
        // Clamp grid size to 2..MAX_GRID
        gs_ext = CMPW'(grid_size);
        if (gs_ext < CMPW'(2))
        begin
            g = GW'(2);
        end
        else if (gs_ext > CMPW'(MAX_GRID))
        begin
            g = GW'(MAX_GRID);
        end
        else
        begin
            g = gs_ext[GW-1:0];
        end

        // Wrap a column left beyond a shrunk grid, restart past the last row
        wrap    = GW'(col_reg) >= g;
        row_t   = wrap ? TW'(row_reg) + TW'(1) : TW'(row_reg);
        restart = row_t > TW'(g);
        col_s   = wrap ? '0 : col_reg;
        row_s   = restart ? '0 : row_t[GW-1:0];
        cnt_s   = restart ? 16'd0 : count_reg;

        col_inc = GW'(col_s) + GW'(1);
        col_end = col_inc == g;

        pix_take   = (kind == hvn_pkg::KIND_PIXEL) && (row_s < g);
        pix_emit   = pix_take && (row_s != '0);
        flush_emit = (kind == hvn_pkg::KIND_FLUSH) && (row_s == g);
        emit       = accept && (pix_emit || flush_emit);

        vr      = (kind == hvn_pkg::KIND_PIXEL) ? row_s - GW'(1) : g - GW'(1);
        vtx_row = vr[CW-1:0];
        vtx_col = col_s;

        req.has_left  = col_s != '0;
        req.has_right = col_inc < g;
        req.has_down  = vr != '0;
        req.has_up    = kind == hvn_pkg::KIND_PIXEL;
        req.last      = (kind == hvn_pkg::KIND_FLUSH) && col_end;
        req.up_avg    = avg;
        req.index     = cnt_s;

        // Line parity selects the half of the store
        rd_center = {vr[0], col_s};
        rd_left   = {vr[0], col_s - CW'(1)};
        rd_right  = {vr[0], col_s + CW'(1)};
        rd_down   = {~vr[0], col_s};

        wr_en   = accept && pix_take;
        wr_addr = {row_s[0], col_s};
        wr_data = avg;

        col_next   = col_s;
        row_next   = row_s;
        count_next = cnt_s;
        if (pix_take)
        begin
            if (col_end)
            begin
                col_next = '0;
                row_next = row_s + GW'(1);
            end
            else
            begin
                col_next = col_inc[CW-1:0];
            end
        end
        if (pix_emit || flush_emit)
        begin
            count_next = cnt_s + 16'd1;
        end
        if (flush_emit)
        begin
            if (col_end)
            begin
                col_next   = '0;
                row_next   = '0;
                count_next = 16'd0;
            end
            else
            begin
                col_next = col_inc[CW-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg   <= '0;
            row_reg   <= '0;
            count_reg <= 16'd0;
        end
        else if (accept)
        begin
            col_reg   <= col_next;
            row_reg   <= row_next;
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

// ===== sv/hvn_vertex_calc.sv =====
// Vertex datapath: heights, central-difference normals, coordinates, output word.
`default_nettype none

module hvn_vertex_calc #(
    parameter int  MAX_GRID = 256,
    localparam int CW       = $clog2(MAX_GRID)
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               load,
    input  wire hvn_pkg::vtx_req_t  req,
    input  wire logic [CW-1:0]      vtx_row,
    input  wire logic [CW-1:0]      vtx_col,
    input  wire logic [7:0]         avg_center,
    input  wire logic [7:0]         avg_left,
    input  wire logic [7:0]         avg_right,
    input  wire logic [7:0]         avg_down,
    input  wire logic [15:0]        height_gain,
    input  wire logic [22:0]        height_offset,
    input  wire logic [15:0]        position_step,
    input  wire logic [16:0]        texture_step,
    output logic                    free,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic      [23:0]        pos_x,
    output logic signed [23:0]      pos_height,
    output logic      [23:0]        pos_z,
    output logic signed [24:0]      normal_x,
    output logic signed [24:0]      normal_z,
    output logic      [16:0]        tex_u,
    output logic      [16:0]        tex_v,
    output logic      [15:0]        vertex_index,
    output logic                    last
);

    localparam int PW  = CW + 16;
    localparam int PSW = (PW > 24) ? PW : 24;
    localparam int TPW = CW + 17;

    // Stage 1: request, line store data arrives alongside
    logic              v1_reg;
    hvn_pkg::vtx_req_t s1_req_reg;
    logic [CW-1:0]     s1_row_reg;
    logic [CW-1:0]     s1_col_reg;

    // Stage 2: heights and coordinates
    logic               v2_reg;
    logic signed [23:0] hc_reg, hl_reg, hr_reg, hd_reg, hu_reg;
    logic [23:0]        px_reg, pz_reg;
    logic [16:0]        tu_reg, tv_reg;
    logic [15:0]        s2_index_reg;
    logic               s2_last_reg;

    // Stage 3: output word
    logic               v3_reg;
    logic [23:0]        pos_x_reg, pos_z_reg;
    logic signed [23:0] pos_height_reg;
    logic signed [24:0] normal_x_reg, normal_z_reg;
    logic [16:0]        tex_u_reg, tex_v_reg;
    logic [15:0]        index_reg;
    logic               last_reg;

    logic en3, en2;

    logic signed [23:0] hc_next, hl_next, hr_next, hd_next, hu_next;
    logic [PW-1:0]      px_prod, pz_prod;
    logic [PSW-1:0]     px_ext, pz_ext;
    logic [TPW-1:0]     tu_prod, tv_prod;
    logic [23:0]        px_next, pz_next;
    logic [16:0]        tu_next, tv_next;

    // Advance a stage when the one after it has room
    assign en3  = !v3_reg || out_ready;
    assign en2  = !v2_reg || en3;
    assign free = !v1_reg || en2;

    always_comb
    begin
        hc_next = hvn_pkg::height_of(avg_center, height_gain, height_offset);
        hl_next = s1_req_reg.has_left
                ? hvn_pkg::height_of(avg_left, height_gain, height_offset) : '0;
        hr_next = s1_req_reg.has_right
                ? hvn_pkg::height_of(avg_right, height_gain, height_offset) : '0;
        hd_next = s1_req_reg.has_down
                ? hvn_pkg::height_of(avg_down, height_gain, height_offset) : '0;
        hu_next = s1_req_reg.has_up
                ? hvn_pkg::height_of(s1_req_reg.up_avg, height_gain, height_offset) : '0;

        px_prod = PW'(s1_col_reg) * PW'(position_step);
        pz_prod = PW'(s1_row_reg) * PW'(position_step);
        px_ext  = PSW'(px_prod);
        pz_ext  = PSW'(pz_prod);
        px_next = (px_ext > PSW'(hvn_pkg::POS_MAX)) ? hvn_pkg::POS_MAX : px_ext[23:0];
        pz_next = (pz_ext > PSW'(hvn_pkg::POS_MAX)) ? hvn_pkg::POS_MAX : pz_ext[23:0];

        tu_prod = TPW'(s1_col_reg) * TPW'(texture_step);
        tv_prod = TPW'(s1_row_reg) * TPW'(texture_step);
        tu_next = (tu_prod > TPW'(hvn_pkg::TEX_MAX)) ? hvn_pkg::TEX_MAX : tu_prod[16:0];
        tv_next = (tv_prod > TPW'(hvn_pkg::TEX_MAX)) ? hvn_pkg::TEX_MAX : tv_prod[16:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (free)
            begin
                v1_reg <= load;
            end
            if (en2)
            begin
                v2_reg <= v1_reg;
            end
            if (en3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            s1_req_reg <= req;
            s1_row_reg <= vtx_row;
            s1_col_reg <= vtx_col;
        end
        if (en2 && v1_reg)
        begin
            hc_reg       <= hc_next;
            hl_reg       <= hl_next;
            hr_reg       <= hr_next;
            hd_reg       <= hd_next;
            hu_reg       <= hu_next;
            px_reg       <= px_next;
            pz_reg       <= pz_next;
            tu_reg       <= tu_next;
            tv_reg       <= tv_next;
            s2_index_reg <= s1_req_reg.index;
            s2_last_reg  <= s1_req_reg.last;
        end
        if (en3 && v2_reg)
        begin
            pos_x_reg      <= px_reg;
            pos_height_reg <= hc_reg;
            pos_z_reg      <= pz_reg;
            normal_x_reg   <= {hl_reg[23], hl_reg} - {hr_reg[23], hr_reg};
            normal_z_reg   <= {hd_reg[23], hd_reg} - {hu_reg[23], hu_reg};
            tex_u_reg      <= tu_reg;
            tex_v_reg      <= tv_reg;
            index_reg      <= s2_index_reg;
            last_reg       <= s2_last_reg;
        end
    end

    assign out_valid    = v3_reg;
    assign pos_x        = pos_x_reg;
    assign pos_height   = pos_height_reg;
    assign pos_z        = pos_z_reg;
    assign normal_x     = normal_x_reg;
    assign normal_z     = normal_z_reg;
    assign tex_u        = tex_u_reg;
    assign tex_v        = tex_v_reg;
    assign vertex_index = index_reg;
    assign last         = last_reg;

endmodule

`default_nettype wire

// ===== sv/heightmap_vertex_normal_stream.sv =====
// Top level of the heightmap vertex normal stream: config registers and wiring.
//
//  channel  direction  handshake                  payload
//  -------  ---------  -------------------------  ----------------------------------------
//  in       sink       in_valid / in_ready        kind, red, green, blue
//  out      source     out_valid / out_ready      pos_x, pos_height, pos_z, normal_x,
//                                                 normal_z, tex_u, tex_v, vertex_index, last
//  cfg      sink       cfg_write (no wait)        cfg_index, cfg_data
//
// A stalled output holds its word; input is ready, for one word per cycle, while
// a pipeline slot is free. A vertex passes the request, height and output registers
// after the word that causes it. A word's store reads and write happen in the cycle
// it is accepted, on two copies of the store with one write and two read ports each.
// Reset clears the raster counters and the pipeline valids; the store is not cleared.
`default_nettype none

module heightmap_vertex_normal_stream #(
    parameter int MAX_GRID = 256
) (
    input  wire logic               clk,
    input  wire logic               rst_n,

    input  wire logic               cfg_write,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [22:0]        cfg_data,

    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic               kind,
    input  wire logic [7:0]         red,
    input  wire logic [7:0]         green,
    input  wire logic [7:0]         blue,

    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic      [23:0]        pos_x,
    output logic signed [23:0]      pos_height,
    output logic      [23:0]        pos_z,
    output logic signed [24:0]      normal_x,
    output logic signed [24:0]      normal_z,
    output logic      [16:0]        tex_u,
    output logic      [16:0]        tex_v,
    output logic      [15:0]        vertex_index,
    output logic                    last
);

    localparam int CW = $clog2(MAX_GRID);
    localparam int AW = CW + 1;

    // Configuration registers
    logic [8:0]  grid_size_reg;
    logic [15:0] height_gain_reg;
    logic [22:0] height_offset_reg;
    logic [15:0] position_step_reg;
    logic [16:0] texture_step_reg;

    logic              accept;
    logic              emit;
    hvn_pkg::vtx_req_t req;
    logic [CW-1:0]     vtx_row;
    logic [CW-1:0]     vtx_col;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [7:0]        wr_data;
    logic [AW-1:0]     rd_center, rd_left, rd_right, rd_down;
    logic [7:0]        avg_center, avg_left, avg_right, avg_down;

    // Take the register write at once; indexes past the list drop
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_size_reg     <= hvn_pkg::GRID_SIZE_RST;
            height_gain_reg   <= hvn_pkg::HEIGHT_GAIN_RST;
            height_offset_reg <= hvn_pkg::HEIGHT_OFFSET_RST;
            position_step_reg <= hvn_pkg::POSITION_STEP_RST;
            texture_step_reg  <= hvn_pkg::TEXTURE_STEP_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                hvn_pkg::CFG_GRID_SIZE:     grid_size_reg     <= cfg_data[8:0];
                hvn_pkg::CFG_HEIGHT_GAIN:   height_gain_reg   <= cfg_data[15:0];
                hvn_pkg::CFG_HEIGHT_OFFSET: height_offset_reg <= cfg_data;
                hvn_pkg::CFG_POSITION_STEP: position_step_reg <= cfg_data[15:0];
                hvn_pkg::CFG_TEXTURE_STEP:  texture_step_reg  <= cfg_data[16:0];
                default:                    ;
            endcase
        end
    end

    // A word is taken whenever the first pipeline slot can load
    assign accept = in_valid && in_ready;

    // Raster counters, store addressing, vertex requests
    hvn_frame_ctrl #(
        .MAX_GRID (MAX_GRID)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .grid_size (grid_size_reg),
        .accept    (accept),
        .kind      (kind),
        .red       (red),
        .green     (green),
        .blue      (blue),
        .emit      (emit),
        .req       (req),
        .vtx_row   (vtx_row),
        .vtx_col   (vtx_col),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_center (rd_center),
        .rd_left   (rd_left),
        .rd_right  (rd_right),
        .rd_down   (rd_down)
    );

    // Two identical copies of the two-line store give four reads per word.
    // The down read hits the entry being overwritten and returns the old row.
    hvn_line_store #(
        .ADDR_W (AW)
    ) u_store_a (
        .clk       (clk),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_en     (emit),
        .rd_addr_a (rd_center),
        .rd_addr_b (rd_left),
        .rd_data_a (avg_center),
        .rd_data_b (avg_left)
    );

    hvn_line_store #(
        .ADDR_W (AW)
    ) u_store_b (
        .clk       (clk),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_en     (emit),
        .rd_addr_a (rd_right),
        .rd_addr_b (rd_down),
        .rd_data_a (avg_right),
        .rd_data_b (avg_down)
    );

    // Heights, normals, coordinates and the output register
    hvn_vertex_calc #(
        .MAX_GRID (MAX_GRID)
    ) u_calc (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (emit),
        .req           (req),
        .vtx_row       (vtx_row),
        .vtx_col       (vtx_col),
        .avg_center    (avg_center),
        .avg_left      (avg_left),
        .avg_right     (avg_right),
        .avg_down      (avg_down),
        .height_gain   (height_gain_reg),
        .height_offset (height_offset_reg),
        .position_step (position_step_reg),
        .texture_step  (texture_step_reg),
        .free          (in_ready),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .pos_x         (pos_x),
        .pos_height    (pos_height),
        .pos_z         (pos_z),
        .normal_x      (normal_x),
        .normal_z      (normal_z),
        .tex_u         (tex_u),
        .tex_v         (tex_v),
        .vertex_index  (vertex_index),
        .last          (last)
    );

endmodule

`default_nettype wire
